@@ rtl/core/vss_pkg.sv @@
package vss_pkg;

  // Time base: one item per 10 ms tick
  localparam int unsigned TickMs = 10;

  // Elapsed time only matters against 16-bit limits, so the counter saturates
  // one bit above them
  localparam int unsigned ElapsedWidth = 17;
  localparam logic [ElapsedWidth-1:0] ElapsedMax = '1;
  localparam logic [ElapsedWidth-1:0] ElapsedSatLimit = ElapsedMax - ElapsedWidth'(TickMs);

  // Configuration register indexes
  localparam logic CfgBootTimeout = 1'b0;
  localparam logic CfgSpeakerTime = 1'b1;

  localparam logic [15:0] BootTimeoutReset = 16'd5000;
  localparam logic [15:0] SpeakerTimeReset = 16'd2000;

  // Dashboard status codes
  localparam logic [2:0] DashLogo     = 3'd0;
  localparam logic [2:0] DashSelect   = 3'd1;
  localparam logic [2:0] DashAck      = 3'd2;
  localparam logic [2:0] DashHv       = 3'd3;
  localparam logic [2:0] DashMotors   = 3'd4;
  localparam logic [2:0] DashShutdown = 3'd5;

  // Accumulator status codes
  localparam logic [1:0] PackIdle    = 2'd0;
  localparam logic [1:0] PackRunning = 2'd1;
  localparam logic [1:0] PackError   = 2'd2;

  // Motor status codes
  localparam logic [1:0] DriveRunning = 2'd1;
  localparam logic [1:0] DriveError   = 2'd2;

  // Sequencer states; error is held internally and reported as zero
  typedef enum logic [3:0] {
    SEQ_START_DASH      = 4'd0,
    SEQ_WAIT_DRIVER     = 4'd1,
    SEQ_WAIT_HV         = 4'd2,
    SEQ_STARTING_HV     = 4'd3,
    SEQ_WAIT_MOTOR      = 4'd4,
    SEQ_STARTING_MOTORS = 4'd5,
    SEQ_READY           = 4'd6,
    SEQ_RUNNING         = 4'd7,
    SEQ_SHUTDOWN        = 4'd8,
    SEQ_ERROR           = 4'd9
  } seq_state_t;

  typedef struct packed {
    logic              dash_valid;
    logic [2:0]        dash_state;
    logic [3:0]        dash_profile;
    logic [1:0]        pack_state;
    logic [1:0]        drive_state;
    logic              brake_pressed;
    logic signed [15:0] torque_in;
  } item_t;

  typedef struct packed {
    logic [3:0]        seq_state;
    logic              pack_enable;
    logic              motor_enable;
    logic              speaker_on;
    logic signed [15:0] torque_out;
    logic              profile_write;
    logic [3:0]        profile_out;
    logic              boot_timeout_alert;
    logic              in_error;
  } result_t;

  typedef struct packed {
    logic [15:0] boot_timeout_ms;
    logic [15:0] speaker_time_ms;
  } cfg_t;

endpackage

@@ rtl/core/vss_in_if.sv @@
interface vss_in_if;
  logic              valid;
  logic              ready;
  logic              dash_valid;
  logic [2:0]        dash_state;
  logic [3:0]        dash_profile;
  logic [1:0]        pack_state;
  logic [1:0]        drive_state;
  logic              brake_pressed;
  logic signed [15:0] torque_in;

  modport source (
    output valid, dash_valid, dash_state, dash_profile, pack_state, drive_state,
           brake_pressed, torque_in,
    input  ready
  );

  modport sink (
    input  valid, dash_valid, dash_state, dash_profile, pack_state, drive_state,
           brake_pressed, torque_in,
    output ready
  );
endinterface

@@ rtl/core/vss_out_if.sv @@
interface vss_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        seq_state;
  logic              pack_enable;
  logic              motor_enable;
  logic              speaker_on;
  logic signed [15:0] torque_out;
  logic              profile_write;
  logic [3:0]        profile_out;
  logic              boot_timeout_alert;
  logic              in_error;

  modport source (
    output valid, seq_state, pack_enable, motor_enable, speaker_on, torque_out,
           profile_write, profile_out, boot_timeout_alert, in_error,
    input  ready
  );

  modport sink (
    input  valid, seq_state, pack_enable, motor_enable, speaker_on, torque_out,
           profile_write, profile_out, boot_timeout_alert, in_error,
    output ready
  );
endinterface

@@ rtl/core/vss_ctrl.sv @@
// Start-up state machine, tick timer and boot alert. Result is combinational
// from the current item and state; state moves when advance is high.
module vss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  vss_pkg::item_t   item,
  input  logic             advance,
  input  vss_pkg::cfg_t    cfg,
  output vss_pkg::result_t result
);

  vss_pkg::seq_state_t seq_reg;
  vss_pkg::seq_state_t seq_next;
  logic [vss_pkg::ElapsedWidth-1:0] elapsed_ms;
  logic [vss_pkg::ElapsedWidth-1:0] elapsed_ms_next;
  logic boot_alert_latch;
  logic alert_set;
  logic dv;

  assign dv = item.dash_valid;

  // Next state
  always_comb begin
    seq_next = seq_reg;
    case (seq_reg)
      vss_pkg::SEQ_START_DASH: begin
        if (dv && (item.dash_state inside {vss_pkg::DashLogo, vss_pkg::DashSelect}))
          seq_next = vss_pkg::SEQ_WAIT_DRIVER;
      end
      vss_pkg::SEQ_WAIT_DRIVER: begin
        if (dv && item.dash_state == vss_pkg::DashAck) seq_next = vss_pkg::SEQ_WAIT_HV;
      end
      vss_pkg::SEQ_WAIT_HV: begin
        if (dv && item.dash_state == vss_pkg::DashHv) seq_next = vss_pkg::SEQ_STARTING_HV;
      end
      vss_pkg::SEQ_STARTING_HV: begin
        if (item.pack_state == vss_pkg::PackRunning) seq_next = vss_pkg::SEQ_WAIT_MOTOR;
        else if (item.pack_state == vss_pkg::PackError) seq_next = vss_pkg::SEQ_ERROR;
      end
      vss_pkg::SEQ_WAIT_MOTOR: begin
        if (dv && item.dash_state == vss_pkg::DashMotors)
          seq_next = vss_pkg::SEQ_STARTING_MOTORS;
      end
      vss_pkg::SEQ_STARTING_MOTORS: begin
        if (item.drive_state == vss_pkg::DriveRunning) seq_next = vss_pkg::SEQ_READY;
        else if (item.drive_state == vss_pkg::DriveError) seq_next = vss_pkg::SEQ_ERROR;
      end
      vss_pkg::SEQ_READY: begin
        if (item.brake_pressed) seq_next = vss_pkg::SEQ_RUNNING;
      end
      vss_pkg::SEQ_RUNNING: begin
        // dashboard shutdown wins over a fault in the same tick
        if (dv && item.dash_state == vss_pkg::DashShutdown)
          seq_next = vss_pkg::SEQ_SHUTDOWN;
        else if (item.pack_state == vss_pkg::PackError ||
                 item.drive_state == vss_pkg::DriveError)
          seq_next = vss_pkg::SEQ_ERROR;
      end
      vss_pkg::SEQ_SHUTDOWN: begin
        if (item.pack_state == vss_pkg::PackIdle) seq_next = vss_pkg::SEQ_START_DASH;
      end
      default: begin
        // error: only a dashboard shutdown leaves it
        if (dv && item.dash_state == vss_pkg::DashShutdown)
          seq_next = vss_pkg::SEQ_SHUTDOWN;
      end
    endcase
  end

  // Outputs of the state held at the start of the tick; the reported state code and error flag come from the next state
  always_comb begin
    result = '0;
    alert_set = 1'b0;
    case (seq_reg)
      vss_pkg::SEQ_START_DASH: begin
        alert_set = (seq_next == vss_pkg::SEQ_START_DASH) &&
                    (elapsed_ms > {1'b0, cfg.boot_timeout_ms});
      end
      vss_pkg::SEQ_WAIT_DRIVER: begin
        if (seq_next == vss_pkg::SEQ_WAIT_HV) begin
          result.profile_write = 1'b1;
          result.profile_out   = item.dash_profile;
        end
      end
      vss_pkg::SEQ_STARTING_HV, vss_pkg::SEQ_WAIT_MOTOR: begin
        result.pack_enable = 1'b1;
      end
      vss_pkg::SEQ_STARTING_MOTORS, vss_pkg::SEQ_READY: begin
        result.pack_enable  = 1'b1;
        result.motor_enable = 1'b1;
      end
      vss_pkg::SEQ_RUNNING: begin
        result.pack_enable  = 1'b1;
        result.motor_enable = 1'b1;
        result.speaker_on   = elapsed_ms < {1'b0, cfg.speaker_time_ms};
        result.torque_out   = item.torque_in;
      end
      default: begin
        result.pack_enable = 1'b0;
      end
    endcase
    result.in_error           = (seq_next == vss_pkg::SEQ_ERROR);
    result.seq_state          = result.in_error ? 4'd0 : seq_next;
    result.boot_timeout_alert = boot_alert_latch | alert_set;
  end

  // Tick timer: clears on a state change, otherwise counts up by TickMs and saturates
  always_comb begin
    if (seq_next != seq_reg) elapsed_ms_next = '0;
    else if (elapsed_ms > vss_pkg::ElapsedSatLimit) elapsed_ms_next = vss_pkg::ElapsedMax;
    else elapsed_ms_next = elapsed_ms + vss_pkg::ElapsedWidth'(vss_pkg::TickMs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_reg          <= vss_pkg::SEQ_START_DASH;
      elapsed_ms       <= '0;
      boot_alert_latch <= 1'b0;
    end else if (advance) begin
      seq_reg          <= seq_next;
      elapsed_ms       <= elapsed_ms_next;
      boot_alert_latch <= boot_alert_latch | alert_set;
    end
  end

  // Alert is sticky until reset
  a_alert_sticky: assert property (@(posedge clk) disable iff (rst)
    boot_alert_latch |=> boot_alert_latch)
    else $error("boot alert cleared without reset");

  // A state change restarts the timer
  a_timer_clear: assert property (@(posedge clk) disable iff (rst)
    (advance && seq_next != seq_reg) |=> elapsed_ms == '0)
    else $error("timer not cleared on state change");

  // Nothing moves without an item
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(seq_reg) && $stable(elapsed_ms)))
    else $error("sequencer state moved without an item");

endmodule

@@ rtl/core/vehicle_startup_sequencer_core.sv @@
// Vehicle start-up sequencer. Feed one item per 10 ms tick on in_ch; each item
// gives exactly one result on out_ch. The block takes one item every clock
// cycle when out_ch keeps up; an item is held in the input register, and its
// result is captured in the result register, which drives out_ch (one input
// register, one result register); the per-tick state update is a loop
// through the state and timer registers. When out_ch stalls, one item waits
// in the input register and in_ch stalls after that. Register 0 sets the
// dashboard boot timeout, register 1 the speaker time, both in ms; write them
// only while no item is in flight.
module vehicle_startup_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  vss_in_if.sink      in_ch,
  vss_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  vss_pkg::cfg_t    cfg;
  vss_pkg::item_t   s1_item;
  logic             s1_valid;
  vss_pkg::result_t result;
  vss_pkg::result_t out_data;
  logic             out_valid;
  logic             out_free;
  logic             advance;
  logic             in_xfer;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_timeout_ms <= vss_pkg::BootTimeoutReset;
      cfg.speaker_time_ms <= vss_pkg::SpeakerTimeReset;
    end else if (cfg_we) begin
      case (cfg_index)
        vss_pkg::CfgBootTimeout: cfg.boot_timeout_ms <= cfg_data;
        vss_pkg::CfgSpeakerTime: cfg.speaker_time_ms <= cfg_data;
        default: cfg.boot_timeout_ms <= cfg.boot_timeout_ms;
      endcase
    end
  end

  // Handshake
  assign out_free    = !out_valid || out_ch.ready;
  assign advance     = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (in_xfer) s1_valid <= 1'b1;
    else if (out_free) s1_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item.dash_valid    <= in_ch.dash_valid;
      s1_item.dash_state    <= in_ch.dash_state;
      s1_item.dash_profile  <= in_ch.dash_profile;
      s1_item.pack_state    <= in_ch.pack_state;
      s1_item.drive_state   <= in_ch.drive_state;
      s1_item.brake_pressed <= in_ch.brake_pressed;
      s1_item.torque_in     <= in_ch.torque_in;
    end
  end

  vss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .item    (s1_item),
    .advance (advance),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (advance) out_data <= result;
  end

  assign out_ch.valid              = out_valid;
  assign out_ch.seq_state          = out_data.seq_state;
  assign out_ch.pack_enable        = out_data.pack_enable;
  assign out_ch.motor_enable       = out_data.motor_enable;
  assign out_ch.speaker_on         = out_data.speaker_on;
  assign out_ch.torque_out         = out_data.torque_out;
  assign out_ch.profile_write      = out_data.profile_write;
  assign out_ch.profile_out        = out_data.profile_out;
  assign out_ch.boot_timeout_alert = out_data.boot_timeout_alert;
  assign out_ch.in_error           = out_data.in_error;

  // Profile strobe only on the step into wait-HV
  a_profile_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.profile_write) |-> out_data.seq_state == vss_pkg::SEQ_WAIT_HV)
    else $error("profile strobe outside selection ack");

  // Error reports state zero
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.in_error) |-> out_data.seq_state == 4'd0)
    else $error("error state not reported as zero");

  // Torque passes only with both enables on
  a_torque_gate: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.torque_out != 16'sd0) |->
      (out_data.pack_enable && out_data.motor_enable))
    else $error("torque passed while drive not enabled");

endmodule
